// ===== hw/rtl/ppsc_pkg.sv =====
// Shared types, widths and constants for the power sharpening block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ppsc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int NB        = 8;                 // buckets per word
  localparam int PW        = FRAC_BITS + 1;     // probability width
  localparam int GW        = FRAC_BITS + 2;     // gain register width
  localparam int AW        = FRAC_BITS + 3;     // alpha width
  localparam int SW        = FRAC_BITS + 4;     // width of a sum of NB probabilities
  localparam int LOG_BITS  = 24;
  localparam int WORK_BITS = 30;
  localparam int YW        = WORK_BITS + 1;
  localparam int MW        = $clog2(FRAC_BITS + 1);
  localparam int EXP_K_MAX = 40;
  localparam int N1_W      = 2 * FRAC_BITS + 1; // renormalize numerator
  localparam int SP_W      = PW + SW + 1;       // spread numerator
  localparam int EIGHTH    = ONE >> 3;

  // register indexes
  localparam logic REG_BUCKET_CAP = 1'b0;
  localparam logic REG_ALPHA_GAIN = 1'b1;

  // out_tuser bits
  localparam int USER_CAPPED  = 0;
  localparam int USER_UNIFORM = 1;

  typedef logic [PW-1:0]          prob_t;
  typedef logic [NB-1:0][PW-1:0]  prob_vec_t;
  typedef logic [AW-1:0]          alpha_t;
  typedef logic [SW-1:0]          sum_t;

  typedef struct packed {
    prob_vec_t       vc;
    logic [NB-1:0]   bm;
    logic            spread_en;
    logic            capped;
    logic            uniform;
  } clip_t;

  typedef struct packed {
    prob_vec_t       v2;
    logic            capped;
    logic            uniform;
    logic            total_zero;
  } merge_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-idx) in Q.30
  function automatic logic [YW-1:0] exp_coef(input int idx);
    logic [63:0] c;
    c = 64'd1 << (WORK_BITS - 1);
    for (int j = 1; j <= idx; j++) c = isqrt64(c << WORK_BITS);
    return c[YW-1:0];
  endfunction

endpackage

// ===== hw/rtl/probability_power_sharpen_cap.sv =====
// Top level of the power sharpening block: input stage, power unit, sum, three
// dividers, clip, merge, output. Uses ppsc_pkg and all ppsc_* modules but the checker.
`timescale 1ns / 1ps

// Takes one word of eight Q1.16 bucket probabilities plus a quality factor and
// returns the sharpened, capped and renormalized set (input stage 1, power unit 51
// for its 24 log and 24 exp steps, sum 1, three dividers of 18 each, clip 2, merge
// 2, output 1). Throughput is one word per cycle while the output is not stalled.
// The whole pipeline advances together: while a result sits in the output register
// unaccepted, in_tready is low and every stage holds. No clearing pass is needed
// after reset. bucket_cap and alpha_gain are read directly by words in flight, so
// write them only while the block is empty.
module probability_power_sharpen_cap (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_up0, in_up1, in_up2, in_up3, in_dn0, in_dn1, in_dn2, in_dn3, quality; 17 b each
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_up0, out_up1, out_up2, out_up3, out_dn0, out_dn1, out_dn2, out_dn3; 17 b each
  output logic [135:0] out_tdata,
  // was_capped, went_uniform
  output logic [1:0]   out_tuser,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [17:0]  cfg_wdata
);

  localparam int NB = ppsc_pkg::NB;
  localparam int PW = ppsc_pkg::PW;
  localparam int QPW = 2 * PW + 1;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // configuration
  ppsc_pkg::prob_t     cap_r;
  logic [ppsc_pkg::GW-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= PW'(62259);
      gain_r <= ppsc_pkg::GW'(98304);
    end else if (cfg_we) begin
      case (cfg_idx)
        ppsc_pkg::REG_BUCKET_CAP: cap_r  <= cfg_wdata[PW-1:0];
        ppsc_pkg::REG_ALPHA_GAIN: gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage: clamp and quality product
  ppsc_pkg::prob_vec_t xin;
  ppsc_pkg::prob_t     qin;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      xin[i] = (in_tdata[i*PW +: PW] > PW'(ppsc_pkg::ONE)) ? PW'(ppsc_pkg::ONE)
                                                         : in_tdata[i*PW +: PW];
    end
    qin = (in_tdata[NB*PW +: PW] > PW'(ppsc_pkg::ONE)) ? PW'(ppsc_pkg::ONE)
                                                     : in_tdata[NB*PW +: PW];
  end

  logic                    p0_vld_r;
  ppsc_pkg::prob_vec_t     p0_x_r;
  logic [ppsc_pkg::GW+PW-1:0] p0_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p0_vld_r <= 1'b0;
    else if (en) p0_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_x_r    <= xin;
      p0_prod_r <= (ppsc_pkg::GW+PW)'(gain_r) * (ppsc_pkg::GW+PW)'(qin);
    end
  end

  ppsc_pkg::alpha_t alpha;
  assign alpha = ppsc_pkg::AW'(ppsc_pkg::ONE)
               + ppsc_pkg::AW'(((QPW+2)'(p0_prod_r) + (QPW+2)'(ppsc_pkg::ONE / 2))
                               >> ppsc_pkg::FRAC_BITS);

  logic                pw_vld;
  ppsc_pkg::prob_vec_t pw_v;

  ppsc_power u_power (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (p0_vld_r),
    .in_x     (p0_x_r),
    .in_alpha (alpha),
    .out_vld  (pw_vld),
    .out_v    (pw_v)
  );

  // sum of powered values
  ppsc_pkg::sum_t      sum;
  logic                sm_vld_r;
  ppsc_pkg::prob_vec_t sm_v_r;
  ppsc_pkg::sum_t      sm_sum_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NB; i++) sum = sum + ppsc_pkg::SW'(pw_v[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sm_vld_r <= 1'b0;
    else if (en) sm_vld_r <= pw_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_v_r   <= pw_v;
      sm_sum_r <= sum;
    end
  end

  logic [NB-1:0][ppsc_pkg::N1_W-1:0] n1_num;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      n1_num[i] = (ppsc_pkg::N1_W'(sm_v_r[i]) << ppsc_pkg::FRAC_BITS)
                + ppsc_pkg::N1_W'(sm_sum_r >> 1);
    end
  end

  logic                d1_vld;
  ppsc_pkg::prob_vec_t d1_q;
  logic                d1_uniform;

  ppsc_div #(.NUM_W(ppsc_pkg::N1_W), .SIDE_W(1)) u_div_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sm_vld_r),
    .in_num   (n1_num),
    .in_den   (sm_sum_r),
    .in_side  (sm_sum_r == '0),
    .out_vld  (d1_vld),
    .out_q    (d1_q),
    .out_side (d1_uniform)
  );

  logic                                 cl_vld;
  logic [NB-1:0][ppsc_pkg::SP_W-1:0]    cl_num;
  ppsc_pkg::sum_t                       cl_den;
  ppsc_pkg::clip_t                      cl_side;

  ppsc_clip u_clip (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (d1_vld),
    .in_q       (d1_q),
    .in_uniform (d1_uniform),
    .cap        (cap_r),
    .out_vld    (cl_vld),
    .out_num    (cl_num),
    .out_den    (cl_den),
    .out_side   (cl_side)
  );

  logic                d2_vld;
  ppsc_pkg::prob_vec_t d2_q;
  ppsc_pkg::clip_t     d2_side;

  ppsc_div #(.NUM_W(ppsc_pkg::SP_W), .SIDE_W($bits(ppsc_pkg::clip_t))) u_div_spread (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (cl_vld),
    .in_num   (cl_num),
    .in_den   (cl_den),
    .in_side  (cl_side),
    .out_vld  (d2_vld),
    .out_q    (d2_q),
    .out_side (d2_side)
  );

  logic                                 mg_vld;
  logic [NB-1:0][ppsc_pkg::N1_W-1:0]    mg_num;
  ppsc_pkg::sum_t                       mg_den;
  ppsc_pkg::merge_t                     mg_side;

  ppsc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d2_vld),
    .in_q     (d2_q),
    .in_side  (d2_side),
    .cap      (cap_r),
    .out_vld  (mg_vld),
    .out_num  (mg_num),
    .out_den  (mg_den),
    .out_side (mg_side)
  );

  logic                d3_vld;
  ppsc_pkg::prob_vec_t d3_q;
  ppsc_pkg::merge_t    d3_side;

  ppsc_div #(.NUM_W(ppsc_pkg::N1_W), .SIDE_W($bits(ppsc_pkg::merge_t))) u_div_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (mg_vld),
    .in_num   (mg_num),
    .in_den   (mg_den),
    .in_side  (mg_side),
    .out_vld  (d3_vld),
    .out_q    (d3_q),
    .out_side (d3_side)
  );

  // renormalized values only when something was clipped and the total is nonzero
  ppsc_pkg::prob_vec_t fin;
  assign fin = (d3_side.capped && !d3_side.total_zero) ? d3_q : d3_side.v2;

  logic                out_vld_r;
  ppsc_pkg::prob_vec_t out_v_r;
  logic [1:0]          out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= d3_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_v_r <= fin;
      out_user_r[ppsc_pkg::USER_CAPPED]  <= d3_side.capped;
      out_user_r[ppsc_pkg::USER_UNIFORM] <= d3_side.uniform;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_v_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== hw/rtl/ppsc_power.sv =====
// Eight-lane x^alpha unit: log2 by repeated squaring, scale, exp2 by coefficients.
// One register stage per log or exp step. Depends on ppsc_pkg.
`timescale 1ns / 1ps

module ppsc_power (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  ppsc_pkg::prob_vec_t in_x,
  input  ppsc_pkg::alpha_t    in_alpha,
  output logic                out_vld,
  output ppsc_pkg::prob_vec_t out_v
);

  localparam int NB  = ppsc_pkg::NB;
  localparam int YW  = ppsc_pkg::YW;
  localparam int LB  = ppsc_pkg::LOG_BITS;
  localparam int MW  = ppsc_pkg::MW;
  localparam int NLW = LB + MW;
  localparam int PRW = NLW + ppsc_pkg::AW;
  localparam int EW  = PRW + 1 - ppsc_pkg::FRAC_BITS;
  localparam int KW  = EW - LB;
  localparam int SHW = $clog2(ppsc_pkg::WORK_BITS + 1) + 1;
  localparam int RW  = 64;

  // log side
  logic                           lg_vld_r  [0:LB];
  logic [NB-1:0][YW-1:0]          lg_y_r    [0:LB];
  logic [NB-1:0][LB-1:0]          lg_bits_r [0:LB];
  logic [NB-1:0][MW-1:0]          lg_nm_r   [0:LB];
  ppsc_pkg::prob_vec_t            lg_x_r    [0:LB];
  ppsc_pkg::alpha_t               lg_a_r    [0:LB];

  // exp side
  logic                           ex_vld_r  [0:LB];
  logic [NB-1:0][YW-1:0]          ex_r_r    [0:LB];
  logic [NB-1:0][LB-1:0]          ex_f_r    [0:LB];
  logic [NB-1:0][KW-1:0]          ex_k_r    [0:LB];
  ppsc_pkg::prob_vec_t            ex_x_r    [0:LB];
  ppsc_pkg::alpha_t               ex_a_r    [0:LB];

  logic [NB-1:0][MW-1:0]          msb;
  logic [NB-1:0][YW-1:0]          y0;
  logic [NB-1:0][MW-1:0]          nm0;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      msb[i] = '0;
      for (int j = 0; j < ppsc_pkg::PW; j++) begin
        if (in_x[i][j]) msb[i] = MW'(j);
      end
      y0[i]  = YW'(in_x[i]) << (SHW'(ppsc_pkg::WORK_BITS) - SHW'(msb[i]));
      nm0[i] = MW'(ppsc_pkg::FRAC_BITS) - msb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) lg_vld_r[0] <= 1'b0;
    else if (en) lg_vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_y_r[0]    <= y0;
      lg_bits_r[0] <= '0;
      lg_nm_r[0]   <= nm0;
      lg_x_r[0]    <= in_x;
      lg_a_r[0]    <= in_alpha;
    end
  end

  // squaring steps: each one yields one fraction bit of log2
  for (genvar s = 1; s <= LB; s++) begin : g_log
    logic [NB-1:0][2*YW-1:0] sq;
    logic [NB-1:0][YW:0]     t;
    logic [NB-1:0][YW-1:0]   y_nxt;
    logic [NB-1:0]           b_nxt;

    always_comb begin
      for (int i = 0; i < NB; i++) begin
        sq[i] = (2*YW)'(lg_y_r[s-1][i]) * (2*YW)'(lg_y_r[s-1][i]);
        t[i]  = sq[i][ppsc_pkg::WORK_BITS +: YW+1];
        b_nxt[i] = t[i][YW];
        y_nxt[i] = t[i][YW] ? t[i][YW:1] : t[i][YW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) lg_vld_r[s] <= 1'b0;
      else if (en) lg_vld_r[s] <= lg_vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_y_r[s] <= y_nxt;
        for (int i = 0; i < NB; i++) begin
          lg_bits_r[s][i] <= {lg_bits_r[s-1][i][LB-2:0], b_nxt[i]};
        end
        lg_nm_r[s] <= lg_nm_r[s-1];
        lg_x_r[s]  <= lg_x_r[s-1];
        lg_a_r[s]  <= lg_a_r[s-1];
      end
    end
  end

  // scale -log2 by alpha
  logic [NB-1:0][NLW-1:0] nl;
  logic [NB-1:0][PRW-1:0] prod;
  logic [NB-1:0][EW-1:0]  e;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      nl[i]   = (NLW'(lg_nm_r[LB][i]) << LB) - NLW'(lg_bits_r[LB][i]);
      prod[i] = PRW'(nl[i]) * PRW'(lg_a_r[LB]);
      e[i]    = EW'(((PRW+1)'(prod[i]) + (PRW+1)'(ppsc_pkg::ONE / 2))
                    >> ppsc_pkg::FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ex_vld_r[0] <= 1'b0;
    else if (en) ex_vld_r[0] <= lg_vld_r[LB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NB; i++) begin
        ex_r_r[0][i] <= YW'(1) << ppsc_pkg::WORK_BITS;
        ex_f_r[0][i] <= e[i][LB-1:0];
        ex_k_r[0][i] <= e[i][EW-1:LB];
      end
      ex_x_r[0] <= lg_x_r[LB];
      ex_a_r[0] <= lg_a_r[LB];
    end
  end

  // exp2 of the fraction, one bit per stage
  for (genvar s = 1; s <= LB; s++) begin : g_exp
    localparam logic [YW-1:0] COEF = ppsc_pkg::exp_coef(s);
    logic [NB-1:0][2*YW-1:0] mul;
    logic [NB-1:0][YW-1:0]   r_nxt;

    always_comb begin
      for (int i = 0; i < NB; i++) begin
        mul[i]   = (2*YW)'(ex_r_r[s-1][i]) * (2*YW)'(COEF);
        r_nxt[i] = ex_f_r[s-1][i][LB-s] ? mul[i][ppsc_pkg::WORK_BITS +: YW]
                                        : ex_r_r[s-1][i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) ex_vld_r[s] <= 1'b0;
      else if (en) ex_vld_r[s] <= ex_vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ex_r_r[s] <= r_nxt;
        ex_f_r[s] <= ex_f_r[s-1];
        ex_k_r[s] <= ex_k_r[s-1];
        ex_x_r[s] <= ex_x_r[s-1];
        ex_a_r[s] <= ex_a_r[s-1];
      end
    end
  end

  // integer part becomes a rounded right shift
  logic [NB-1:0][SHW-1:0]  sh;
  logic [NB-1:0][RW-1:0]   rnd;
  ppsc_pkg::prob_vec_t     res;
  ppsc_pkg::prob_vec_t     out_v_r;
  logic                    out_vld_r;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      sh[i]  = SHW'(ppsc_pkg::WORK_BITS - ppsc_pkg::FRAC_BITS) + SHW'(ex_k_r[LB][i]);
      rnd[i] = (RW'(ex_r_r[LB][i]) + (RW'(1) << (sh[i] - SHW'(1)))) >> sh[i];
      if (ex_x_r[LB][i] == '0) begin
        res[i] = '0;
      end else if (ex_a_r[LB] == ppsc_pkg::AW'(ppsc_pkg::ONE)) begin
        res[i] = ex_x_r[LB][i];
      end else if (ex_k_r[LB][i] >= KW'(ppsc_pkg::EXP_K_MAX)) begin
        res[i] = '0;
      end else begin
        res[i] = rnd[i][ppsc_pkg::PW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= ex_vld_r[LB];
  end

  always_ff @(posedge clk) begin
    if (en) out_v_r <= res;
  end

  assign out_vld = out_vld_r;
  assign out_v   = out_v_r;

endmodule

// ===== hw/rtl/ppsc_div.sv =====
// Pipelined restoring divider, eight numerators over one shared denominator.
// One quotient bit per stage, side data rides along. Depends on ppsc_pkg.
`timescale 1ns / 1ps

module ppsc_div #(
  parameter int NUM_W  = 33,
  parameter int SIDE_W = 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic [ppsc_pkg::NB-1:0][NUM_W-1:0]   in_num,
  input  ppsc_pkg::sum_t                       in_den,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_vld,
  output ppsc_pkg::prob_vec_t                  out_q,
  output logic [SIDE_W-1:0]                    out_side
);

  localparam int NB = ppsc_pkg::NB;
  localparam int QW = ppsc_pkg::PW;
  localparam int DW = ppsc_pkg::SW;

  logic                    vld_r  [0:QW];
  logic [NB-1:0][DW-1:0]   rem_r  [0:QW];
  logic [NB-1:0][QW-1:0]   lq_r   [0:QW];   // numerator bits out the top, quotient in
  logic [DW-1:0]           den_r  [0:QW];
  logic [SIDE_W-1:0]       side_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NB; i++) begin
        rem_r[0][i] <= DW'(in_num[i] >> QW);
        lq_r[0][i]  <= in_num[i][QW-1:0];
      end
      den_r[0]  <= in_den;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [NB-1:0][DW:0]   trial;
    logic [NB-1:0]         ge;
    logic [NB-1:0][DW-1:0] rem_nxt;

    always_comb begin
      for (int i = 0; i < NB; i++) begin
        trial[i]   = {rem_r[s-1][i], lq_r[s-1][i][QW-1]};
        ge[i]      = trial[i] >= {1'b0, den_r[s-1]};
        rem_nxt[i] = ge[i] ? DW'(trial[i] - {1'b0, den_r[s-1]}) : trial[i][DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[s] <= 1'b0;
      else if (en) vld_r[s] <= vld_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        for (int i = 0; i < NB; i++) begin
          lq_r[s][i] <= {lq_r[s-1][i][QW-2:0], ge[i]};
        end
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign out_q    = lq_r[QW];
  assign out_side = side_r[QW];

endmodule

// ===== hw/rtl/ppsc_clip.sv =====
// Cap clipping: clip buckets above the cap, total the excess and the mass below,
// and build the spread numerators for the divider. Depends on ppsc_pkg.
`timescale 1ns / 1ps

module ppsc_clip (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      in_vld,
  input  ppsc_pkg::prob_vec_t                       in_q,
  input  logic                                      in_uniform,
  input  ppsc_pkg::prob_t                           cap,
  output logic                                      out_vld,
  output logic [ppsc_pkg::NB-1:0][ppsc_pkg::SP_W-1:0] out_num,
  output ppsc_pkg::sum_t                            out_den,
  output ppsc_pkg::clip_t                           out_side
);

  localparam int NB = ppsc_pkg::NB;
  localparam int SP = ppsc_pkg::SP_W;

  ppsc_pkg::prob_vec_t v;
  ppsc_pkg::prob_vec_t vc;
  ppsc_pkg::prob_vec_t diff;
  logic [NB-1:0]       over;

  logic                c1_vld_r;
  ppsc_pkg::prob_vec_t c1_vc_r;
  ppsc_pkg::prob_vec_t c1_diff_r;
  logic [NB-1:0]       c1_over_r;
  logic                c1_uniform_r;

  // the uniform fallback is never clipped
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      v[i]    = in_uniform ? ppsc_pkg::PW'(ppsc_pkg::EIGHTH) : in_q[i];
      over[i] = !in_uniform && (v[i] > cap);
      vc[i]   = over[i] ? cap : v[i];
      diff[i] = over[i] ? v[i] - cap : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c1_vld_r <= 1'b0;
    else if (en) c1_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_vc_r      <= vc;
      c1_diff_r    <= diff;
      c1_over_r    <= over;
      c1_uniform_r <= in_uniform;
    end
  end

  ppsc_pkg::sum_t  excess;
  ppsc_pkg::sum_t  below;
  logic [NB-1:0]   bm;

  always_comb begin
    excess = '0;
    below  = '0;
    for (int i = 0; i < NB; i++) begin
      bm[i]  = c1_vc_r[i] < cap;
      excess = excess + ppsc_pkg::SW'(c1_diff_r[i]);
      below  = below + (bm[i] ? ppsc_pkg::SW'(c1_vc_r[i]) : '0);
    end
  end

  logic                c2_vld_r;
  ppsc_pkg::prob_vec_t c2_vc_r;
  logic [NB-1:0]       c2_bm_r;
  ppsc_pkg::sum_t      c2_excess_r;
  ppsc_pkg::sum_t      c2_below_r;
  logic                c2_spread_r;
  logic                c2_capped_r;
  logic                c2_uniform_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_vld_r <= 1'b0;
    else if (en) c2_vld_r <= c1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_vc_r      <= c1_vc_r;
      c2_bm_r      <= bm;
      c2_excess_r  <= excess;
      c2_below_r   <= below;
      c2_spread_r  <= (|c1_over_r) && !(&c1_over_r) && (excess != '0) && (below != '0);
      c2_capped_r  <= |c1_over_r;
      c2_uniform_r <= c1_uniform_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      out_num[i] = c2_bm_r[i] ? SP'(c2_vc_r[i]) * SP'(c2_excess_r) + SP'(c2_below_r >> 1)
                              : '0;
    end
  end

  assign out_vld            = c2_vld_r;
  assign out_den            = c2_below_r;
  assign out_side.vc        = c2_vc_r;
  assign out_side.bm        = c2_bm_r;
  assign out_side.spread_en = c2_spread_r;
  assign out_side.capped    = c2_capped_r;
  assign out_side.uniform   = c2_uniform_r;

endmodule

// ===== hw/rtl/ppsc_merge.sv =====
// Adds the spread share back onto the buckets below the cap, reclips, totals,
// and builds the final renormalize numerators. Depends on ppsc_pkg.
`timescale 1ns / 1ps

module ppsc_merge (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       in_vld,
  input  ppsc_pkg::prob_vec_t                        in_q,
  input  ppsc_pkg::clip_t                            in_side,
  input  ppsc_pkg::prob_t                            cap,
  output logic                                       out_vld,
  output logic [ppsc_pkg::NB-1:0][ppsc_pkg::N1_W-1:0] out_num,
  output ppsc_pkg::sum_t                             out_den,
  output ppsc_pkg::merge_t                           out_side
);

  localparam int NB = ppsc_pkg::NB;
  localparam int PW = ppsc_pkg::PW;
  localparam int NW = ppsc_pkg::N1_W;

  logic [NB-1:0][PW:0]  t;
  ppsc_pkg::prob_vec_t  v2;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      t[i] = (PW+1)'(in_side.vc[i]) + (PW+1)'(in_q[i]);
      if (in_side.spread_en && in_side.bm[i]) begin
        v2[i] = (t[i] < (PW+1)'(cap)) ? t[i][PW-1:0] : cap;
      end else begin
        v2[i] = in_side.vc[i];
      end
    end
  end

  logic                m1_vld_r;
  ppsc_pkg::prob_vec_t m1_v2_r;
  logic                m1_capped_r;
  logic                m1_uniform_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m1_vld_r <= 1'b0;
    else if (en) m1_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_v2_r      <= v2;
      m1_capped_r  <= in_side.capped;
      m1_uniform_r <= in_side.uniform;
    end
  end

  ppsc_pkg::sum_t total;

  always_comb begin
    total = '0;
    for (int i = 0; i < NB; i++) total = total + ppsc_pkg::SW'(m1_v2_r[i]);
  end

  logic                m2_vld_r;
  ppsc_pkg::prob_vec_t m2_v2_r;
  ppsc_pkg::sum_t      m2_total_r;
  logic                m2_capped_r;
  logic                m2_uniform_r;

  always_ff @(posedge clk) begin
    if (!rst_n) m2_vld_r <= 1'b0;
    else if (en) m2_vld_r <= m1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_v2_r      <= m1_v2_r;
      m2_total_r   <= total;
      m2_capped_r  <= m1_capped_r;
      m2_uniform_r <= m1_uniform_r;
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      out_num[i] = (NW'(m2_v2_r[i]) << ppsc_pkg::FRAC_BITS) + NW'(m2_total_r >> 1);
    end
  end

  assign out_vld             = m2_vld_r;
  assign out_den             = m2_total_r;
  assign out_side.v2         = m2_v2_r;
  assign out_side.capped     = m2_capped_r;
  assign out_side.uniform    = m2_uniform_r;
  assign out_side.total_zero = (m2_total_r == '0);

endmodule

// ===== hw/rtl/ppsc_checker.sv =====
// Port-level checks for the power sharpening block, bound to the top level.
// Depends on ppsc_pkg and probability_power_sharpen_cap.
`timescale 1ns / 1ps

module ppsc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [135:0] out_tdata,
  input logic [1:0]   out_tuser
);

  localparam int NB = ppsc_pkg::NB;
  localparam int PW = ppsc_pkg::PW;

  logic [NB-1:0] is_eighth;
  logic          all_eighth;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      is_eighth[i] = out_tdata[i*PW +: PW] == PW'(ppsc_pkg::EIGHTH);
    end
    all_eighth = &is_eighth;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow the output stall");

  a_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[ppsc_pkg::USER_UNIFORM]
      |-> !out_tuser[ppsc_pkg::USER_CAPPED] && all_eighth)
    else $error("uniform word is not all one eighth or is flagged capped");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind probability_power_sharpen_cap ppsc_checker u_ppsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
